FILE: hw/rtl/lel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lel_pkg: shared types and constants of the lower envelope line tree
// Field widths, node store entry layout, sequencer states and evaluation
// point codes.
// ----------------------------------------------------------------------------
package lel_pkg;

	localparam int SLOPE_W    = 25;
	localparam int ICPT_W     = 41;
	localparam int POINT_W    = 10;
	localparam int MIN_W      = 42;
	localparam int X_BITS_DEF = 10;

	// Difference line (new minus stored) operand widths
	localparam int DK_W = SLOPE_W + 1;
	localparam int DC_W = ICPT_W + 1;

	typedef struct packed {
		logic              valid;
		logic [SLOPE_W-1:0] slope;
		logic [ICPT_W-1:0]  intercept;
	} lel_node_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_CHK,
		S_EVAL,
		S_EWAIT,
		S_DEC,
		S_QWAIT,
		S_QNEXT,
		S_DONE
	} lel_state_t;

	typedef enum logic [1:0] {
		PT_MID,
		PT_LO,
		PT_HI
	} lel_pt_t;

	typedef enum logic {
		KIND_INSERT,
		KIND_QUERY
	} lel_kind_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lel_if: request and result channels of the lower envelope line tree
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface lel_req_if import lel_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [SLOPE_W-1:0] slope;
	logic signed [ICPT_W-1:0]  intercept;
	logic signed [POINT_W-1:0] point;

	modport source (output valid, kind, slope, intercept, point, input ready);
	modport sink   (input valid, kind, slope, intercept, point, output ready);
endinterface

interface lel_res_if import lel_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [MIN_W-1:0] minimum;
	logic                    empty_res;

	modport source (output valid, minimum, empty_res, input ready);
	modport sink   (input valid, minimum, empty_res, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lel_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lel_mac: shared multiply-add unit
// Computes a*b + c in two registered steps: multiply, then add.
// ----------------------------------------------------------------------------
module lel_mac import lel_pkg::*; #(
	parameter int X_BITS = X_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic signed [DK_W-1:0]   a,
	input  wire logic signed [X_BITS-1:0] b,
	input  wire logic signed [DC_W-1:0]   c,
	output logic                          done,
	output logic signed [((DK_W + X_BITS > DC_W) ? DK_W + X_BITS : DC_W):0] sum
);

	localparam int PW = DK_W + X_BITS;
	localparam int SW = ((PW > DC_W) ? PW : DC_W) + 1;

	logic signed [PW-1:0]   prod_s1;
	logic signed [DC_W-1:0] c_s1;
	logic                   vld_s1;
	logic signed [SW-1:0]   sum_s2;
	logic                   vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= PW'(a) * PW'(b);
			c_s1    <= c;
		end
		if (vld_s1) begin
			sum_s2 <= SW'(prod_s1) + SW'(c_s1);
		end
	end

	assign done = vld_s2;
	assign sum  = sum_s2;

endmodule
`default_nettype wire

FILE: hw/rtl/lower_envelope_line_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lower_envelope_line_tree: Li Chao tree keeping the lower envelope of lines
// Insert lines y = slope*x + intercept, query the least value at a point.
// ----------------------------------------------------------------------------
// Use:
//   req carries one request: kind 0 inserts (slope, intercept), kind 1 asks
//   for the minimum at point. req.ready is high only while the block is idle.
//   res carries one result per query (none per insert): minimum and
//   empty_res, which is set with minimum zero until a line is inserted.
// Walk (L = X_BITS + 1 tree levels):
//   Query: once a line is stored, visits all L levels and evaluates the
//   stored line at every level that holds one, skipping empty levels.
//   Insert: the single multiply-add unit evaluates the difference line
//   at mid, lo and hi, one after the other, at every level visited that
//   holds a line.
// Reset:
//   After reset a clearing pass walks all 2^(X_BITS+1) node entries, one a
//   cycle, with req.ready low; no line is stored.
// Stall:
//   The result sits in an output register; the next request is taken while
//   it waits. A query that finishes while the previous result is still not
//   taken holds until the register frees up.
// ----------------------------------------------------------------------------
module lower_envelope_line_tree import lel_pkg::*; #(
	parameter int X_BITS = X_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lel_req_if.sink   req,
	lel_res_if.source res
);

	localparam int NODES = 2 ** (X_BITS + 1);
	localparam int AW    = X_BITS + 1;
	localparam int PW    = DK_W + X_BITS;
	localparam int SW    = ((PW > DC_W) ? PW : DC_W) + 1;
	localparam int XW    = (X_BITS > POINT_W) ? X_BITS : POINT_W;

	lel_state_t state_q, state_d;

	// Node store
	lel_node_t mem_q [NODES];
	lel_node_t rd_q;
	lel_node_t wr_data;
	logic      mem_we;
	logic      rd_en;

	// Walk state
	logic [AW-1:0]             node_q;
	logic [X_BITS-1:0]         lo_q, hi_q;
	logic [X_BITS:0]           lohi_sum;
	logic [X_BITS-1:0]         mid;
	logic                      kind_q;
	logic [SLOPE_W-1:0]        k_q;
	logic [ICPT_W-1:0]         c_q;
	logic signed [DK_W-1:0]    dk_q;
	logic signed [DC_W-1:0]    dc_q;
	lel_pt_t                   pt_q;
	logic [2:0]                neg_q, pos_q;
	logic [X_BITS-1:0]         u_q;
	logic signed [X_BITS-1:0]  x_q;
	logic signed [XW-1:0]      pt_ext;
	logic                      found_q;
	logic signed [SW-1:0]      best_q;
	logic                      any_line_q;

	// Result register
	logic                    res_valid_q;
	logic signed [MIN_W-1:0] res_min_q;
	logic                    res_empty_q;
	logic                    res_free;

	// Shared multiply-add
	logic                     mac_go;
	logic signed [DK_W-1:0]   mac_a;
	logic signed [X_BITS-1:0] mac_b;
	logic signed [DC_W-1:0]   mac_c;
	logic                     mac_done;
	logic signed [SW-1:0]     mac_sum;
	logic [X_BITS-1:0]        eval_u;

	logic accept;
	logic swap, go_lo, go_hi, leaf, q_better, sum_neg, sum_pos;

	assign accept   = req.valid && req.ready;
	assign res_free = !res_valid_q || res.ready;

	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[X_BITS:1];
	assign leaf     = (lo_q == hi_q);

	assign pt_ext = XW'(req.point);

	// Position u maps to x = u - 2^(X_BITS-1): flip the top bit
	always_comb begin
		case (pt_q)
			PT_MID:  eval_u = mid;
			PT_LO:   eval_u = lo_q;
			PT_HI:   eval_u = hi_q;
			default: eval_u = mid;
		endcase
	end

	always_comb begin
		if (kind_q == KIND_QUERY) begin
			mac_a = DK_W'($signed(rd_q.slope));
			mac_b = x_q;
			mac_c = DC_W'($signed(rd_q.intercept));
		end else begin
			mac_a = dk_q;
			mac_b = $signed({~eval_u[X_BITS-1], eval_u[X_BITS-2:0]});
			mac_c = dc_q;
		end
	end

	lel_mac #(
		.X_BITS (X_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mac_go),
		.a      (mac_a),
		.b      (mac_b),
		.c      (mac_c),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	assign sum_neg  = mac_sum[SW-1];
	assign sum_pos  = !mac_sum[SW-1] && (mac_sum != '0);
	assign q_better = !found_q || (mac_sum < best_q);

	// After a swap the carried line is the old one, so the difference flips sign
	assign swap  = neg_q[PT_MID];
	assign go_lo = swap ? pos_q[PT_LO] : neg_q[PT_LO];
	assign go_hi = swap ? pos_q[PT_HI] : neg_q[PT_HI];

	assign wr_data = (state_q == S_CLEAR) ? '0 : lel_node_t'{1'b1, k_q, c_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[node_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[node_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		rd_en   = 1'b0;
		mac_go  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (node_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					if (req.kind == KIND_QUERY && !any_line_q) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (kind_q == KIND_QUERY) begin
					if (rd_q.valid) begin
						mac_go  = 1'b1;
						state_d = S_QWAIT;
					end else begin
						state_d = S_QNEXT;
					end
				end else if (!rd_q.valid) begin
					mem_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				mac_go  = 1'b1;
				state_d = S_EWAIT;
			end
			S_EWAIT: begin
				if (mac_done) begin
					state_d = (pt_q == PT_HI) ? S_DEC : S_EVAL;
				end
			end
			S_DEC: begin
				mem_we = swap;
				if (leaf || (!go_lo && !go_hi)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_RD;
				end
			end
			S_QWAIT: begin
				if (mac_done) begin
					state_d = S_QNEXT;
				end
			end
			S_QNEXT: begin
				state_d = leaf ? S_DONE : S_RD;
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q      <= '0;
			any_line_q  <= 1'b0;
			found_q     <= 1'b0;
			pt_q        <= PT_MID;
			kind_q      <= KIND_INSERT;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					node_q <= node_q + AW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						kind_q  <= req.kind;
						node_q  <= AW'(1);
						found_q <= 1'b0;
						if (req.kind == KIND_INSERT) begin
							any_line_q <= 1'b1;
						end
					end
				end
				S_CHK: begin
					pt_q <= PT_MID;
				end
				S_EWAIT: begin
					if (mac_done) begin
						case (pt_q)
							PT_MID:  pt_q <= PT_LO;
							PT_LO:   pt_q <= PT_HI;
							default: pt_q <= PT_MID;
						endcase
					end
				end
				S_DEC: begin
					if (go_lo) begin
						node_q <= {node_q[AW-2:0], 1'b0};
					end else begin
						node_q <= {node_q[AW-2:0], 1'b1};
					end
				end
				S_QWAIT: begin
					if (mac_done && q_better) begin
						found_q <= 1'b1;
					end
				end
				S_QNEXT: begin
					if (u_q <= mid) begin
						node_q <= {node_q[AW-2:0], 1'b0};
					end else begin
						node_q <= {node_q[AW-2:0], 1'b1};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					k_q  <= req.slope;
					c_q  <= req.intercept;
					lo_q <= '0;
					hi_q <= '1;
					x_q  <= pt_ext[X_BITS-1:0];
					u_q  <= {~pt_ext[X_BITS-1], pt_ext[X_BITS-2:0]};
				end
			end
			S_CHK: begin
				dk_q <= DK_W'($signed(k_q)) - DK_W'($signed(rd_q.slope));
				dc_q <= DC_W'($signed(c_q)) - DC_W'($signed(rd_q.intercept));
			end
			S_EWAIT: begin
				if (mac_done) begin
					neg_q[pt_q] <= sum_neg;
					pos_q[pt_q] <= sum_pos;
				end
			end
			S_DEC: begin
				// Keep the lower line here, carry the loser down
				if (swap) begin
					k_q <= rd_q.slope;
					c_q <= rd_q.intercept;
				end
				if (go_lo) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + X_BITS'(1);
				end
			end
			S_QWAIT: begin
				if (mac_done && q_better) begin
					best_q <= mac_sum;
				end
			end
			S_QNEXT: begin
				if (u_q <= mid) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + X_BITS'(1);
				end
			end
			S_DONE: begin
				if (res_free) begin
					res_min_q   <= found_q ? best_q[MIN_W-1:0] : '0;
					res_empty_q <= !any_line_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid     = res_valid_q;
	assign res.minimum   = res_min_q;
	assign res.empty_res = res_empty_q;

endmodule
`default_nettype wire

FILE: tb/sv/lower_envelope_line_tree_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lower_envelope_line_tree_test: self-checking bench for the line envelope tree
// Drives insert and query requests over the request channel with random gaps,
// stalls the result channel at random and compares every result against a
// Li Chao tree kept in the bench, field by field and in order.
// ----------------------------------------------------------------------------
module lower_envelope_line_tree_test import lel_pkg::*; ();

	localparam int LEAF_N      = 1 << X_BITS_DEF;
	localparam int NODE_N      = 2 * LEAF_N;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 200;
	localparam int PHASE_ITEMS = 200;

	localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
	localparam logic signed [ICPT_W-1:0]  ICPT_MAX  = {1'b0, {(ICPT_W-1){1'b1}}};
	localparam logic signed [ICPT_W-1:0]  ICPT_MIN  = {1'b1, {(ICPT_W-1){1'b0}}};
	localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
	localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};
	localparam longint TIE_C_BOUND = 64'sd1 <<< 38;

	typedef struct {
		logic [MIN_W-1:0] minimum;
		logic             empty;
	} envelope_result_t;

	// Mirror of the node store plus the queue of minima still owed by the block
	class envelope_scoreboard;
		bit               held [NODE_N];
		longint           held_k [NODE_N];
		longint           held_c [NODE_N];
		bit               have_line;
		envelope_result_t awaited [$];
		int               errors;

		function longint line_at(longint k, longint c, int u);
			return k * longint'(u - LEAF_N / 2) + c;
		endfunction

		function void place_line(longint k, longint c);
			int     n;
			int     lo;
			int     hi;
			int     mid;
			longint tk;
			longint tc;
			n = 1;
			lo = 0;
			hi = LEAF_N - 1;
			while (1) begin
				if (!held[n]) begin
					held[n] = 1'b1;
					held_k[n] = k;
					held_c[n] = c;
					return;
				end
				mid = (lo + hi) / 2;
				// keep the strictly lower line at the midpoint, carry the other down
				if (line_at(k, c, mid) < line_at(held_k[n], held_c[n], mid)) begin
					tk = held_k[n];
					tc = held_c[n];
					held_k[n] = k;
					held_c[n] = c;
					k = tk;
					c = tc;
				end
				if (lo == hi)
					return;
				if (line_at(k, c, lo) < line_at(held_k[n], held_c[n], lo)) begin
					n = 2 * n;
					hi = mid;
				end else if (line_at(k, c, hi) < line_at(held_k[n], held_c[n], hi)) begin
					n = 2 * n + 1;
					lo = mid + 1;
				end else begin
					return;
				end
			end
		endfunction

		function longint min_at(int u);
			int     n;
			int     lo;
			int     hi;
			int     mid;
			bit     found;
			longint best;
			longint v;
			n = 1;
			lo = 0;
			hi = LEAF_N - 1;
			found = 1'b0;
			best = 0;
			while (1) begin
				if (held[n]) begin
					v = line_at(held_k[n], held_c[n], u);
					if (!found || v < best) begin
						best = v;
						found = 1'b1;
					end
				end
				if (lo == hi)
					break;
				mid = (lo + hi) / 2;
				if (u <= mid) begin
					n = 2 * n;
					hi = mid;
				end else begin
					n = 2 * n + 1;
					lo = mid + 1;
				end
			end
			return best;
		endfunction

		function void note_request(logic kind, logic signed [SLOPE_W-1:0] slope,
				logic signed [ICPT_W-1:0] icpt, logic signed [POINT_W-1:0] point);
			envelope_result_t r;
			int               u;
			longint           m;
			if (kind == KIND_INSERT) begin
				place_line(slope, icpt);
				have_line = 1'b1;
			end else begin
				if (!have_line) begin
					r.minimum = '0;
					r.empty = 1'b1;
				end else begin
					u = (int'(point) + LEAF_N / 2) & (LEAF_N - 1);
					m = min_at(u);
					r.minimum = m[MIN_W-1:0];
					r.empty = 1'b0;
				end
				awaited.push_back(r);
			end
		endfunction

		function void check_result(logic [MIN_W-1:0] minimum, logic empty);
			envelope_result_t r;
			if (awaited.size() == 0) begin
				$display("%0t: result with none awaited: minimum %0d empty %0b",
					$time, $signed(minimum), empty);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (minimum !== r.minimum) begin
				$display("%0t: minimum mismatch: expected %0d, actual %0d",
					$time, $signed(r.minimum), $signed(minimum));
				errors++;
			end
			if (empty !== r.empty) begin
				$display("%0t: empty_res mismatch: expected %0b, actual %0b",
					$time, r.empty, empty);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lel_req_if req_ch ();
	lel_res_if res_ch ();

	lower_envelope_line_tree u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	envelope_scoreboard sb;
	int send_idle;
	int take_idle;
	int cycle_count;
	logic signed [SLOPE_W-1:0] last_k;
	logic signed [ICPT_W-1:0]  last_c;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.minimum, res_ch.empty_res);
		res_ch.ready <= ($urandom_range(99) >= take_idle);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("lower_envelope_line_tree_test: done, errors");
		$finish;
	end

	function automatic logic signed [SLOPE_W-1:0] pick_slope();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return raw[SLOPE_W-1:0];
			1: return SLOPE_W'(int'($urandom_range(16)) - 8);
			2: return $urandom_range(1) ? SLOPE_MAX : SLOPE_MIN;
			default: return SLOPE_W'(int'($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function automatic logic signed [ICPT_W-1:0] pick_icpt();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return raw[ICPT_W-1:0];
			1: return ICPT_W'(int'($urandom_range(2000)) - 1000);
			2: return $urandom_range(1) ? ICPT_MAX : ICPT_MIN;
			default: return ICPT_W'(longint'(int'(raw[31:0])));
		endcase
	endfunction

	function automatic logic signed [POINT_W-1:0] pick_point();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(3))
			0, 1: return raw[POINT_W-1:0];
			2: return $urandom_range(1) ? POINT_MAX : POINT_MIN;
			default: return POINT_W'(int'($urandom_range(8)) - 4);
		endcase
	endfunction

	task automatic send_req(logic kind, logic signed [SLOPE_W-1:0] k,
			logic signed [ICPT_W-1:0] c, logic signed [POINT_W-1:0] x);
		if ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.slope <= k;
		req_ch.intercept <= c;
		req_ch.point <= x;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, k, c, x);
	endtask

	task automatic random_item();
		logic signed [SLOPE_W-1:0] k;
		logic signed [ICPT_W-1:0]  c;
		logic signed [POINT_W-1:0] x;
		longint                    x0;
		k = pick_slope();
		c = pick_icpt();
		x = pick_point();
		if ($urandom_range(99) < 45) begin
			case ($urandom_range(9))
				// repeat the last line: equal everywhere
				0: begin
					k = last_k;
					c = last_c;
				end
				// cross the last line exactly at some point
				1, 2: if (last_k >= -4096 && last_k <= 4096 &&
						longint'(last_c) > -TIE_C_BOUND &&
						longint'(last_c) < TIE_C_BOUND) begin
					k = SLOPE_W'(int'($urandom_range(64)) - 32);
					x0 = longint'(pick_point());
					c = ICPT_W'(longint'(last_c) + (longint'(last_k) - longint'(k)) * x0);
				end
				default: ;
			endcase
			last_k = k;
			last_c = c;
			send_req(KIND_INSERT, k, c, x);
		end else begin
			send_req(KIND_QUERY, k, c, x);
		end
	endtask

	// hold off the sender until every owed result has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_INSERT;
		req_ch.slope = '0;
		req_ch.intercept = '0;
		req_ch.point = '0;
		res_ch.ready = 1'b0;
		send_idle = 32;
		take_idle = 60;
		last_k = '0;
		last_c = '0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty tree
		send_req(KIND_QUERY, SLOPE_MAX, ICPT_MAX, POINT_MIN);
		send_req(KIND_QUERY, SLOPE_MIN, ICPT_MIN, POINT_MAX);
		send_req(KIND_QUERY, -1, -1, 0);
		// extreme lines
		send_req(KIND_INSERT, SLOPE_MAX, ICPT_MAX, POINT_MIN);
		send_req(KIND_QUERY, 0, 0, POINT_MIN);
		send_req(KIND_QUERY, 0, 0, POINT_MAX);
		send_req(KIND_INSERT, SLOPE_MIN, ICPT_MIN, POINT_MAX);
		send_req(KIND_QUERY, 0, 0, POINT_MIN);
		send_req(KIND_QUERY, 0, 0, POINT_MAX);
		send_req(KIND_QUERY, 0, 0, -1);
		// ties: duplicate line, then lines meeting the flat one at the root midpoint
		send_req(KIND_INSERT, 0, 0, 0);
		send_req(KIND_INSERT, 0, 0, 0);
		send_req(KIND_INSERT, 1, 1, 0);
		send_req(KIND_INSERT, -1, -1, 0);
		send_req(KIND_QUERY, 0, 0, -1);
		send_req(KIND_QUERY, 0, 0, 0);
		send_req(KIND_QUERY, 0, 0, -2);
		send_req(KIND_QUERY, 0, 0, 255);
		send_req(KIND_QUERY, 0, 0, -256);
		send_req(KIND_INSERT, 3, ICPT_MIN, 0);
		send_req(KIND_QUERY, 0, 0, 100);
		send_req(KIND_QUERY, SLOPE_MAX, ICPT_MAX, POINT_MIN);
		send_req(KIND_QUERY, SLOPE_MIN, ICPT_MIN, POINT_MAX);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 32;
					take_idle = 60;
				end
				1: begin
					send_idle = 60;
					take_idle = 32;
				end
				default: begin
					send_idle = 0;
					take_idle = 0;
				end
			endcase
			repeat (PHASE_ITEMS) random_item();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("lower_envelope_line_tree_test: done, clean");
		else
			$display("lower_envelope_line_tree_test: done, errors");
		$finish;
	end

endmodule
